>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on i_clk, idle in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must bring a result in the next cycle
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

>>> design/mtfd_pkg.sv
// ---------------------------------------------------------------------------
// mtfd_pkg
// Shared constants and types of the inverse move-to-front decoder.
// ---------------------------------------------------------------------------
package mtfd_pkg;

    // Number of list cells (2 .. 256)
    localparam int LIST_ENTRIES = 256;
    localparam int SYM_W        = 8;
    localparam int POS_W        = 8;
    localparam int CNT_W        = 9;

    // Read-out tree: cells are ORed in groups, then groups are ORed
    localparam int GROUP_SIZE   = 16;
    localparam int NUM_GROUPS   = (LIST_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

    // Item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    // Broadcast control for the cell row
    typedef struct packed {
        logic             load;   // write data into the cell at pos
        logic             move;   // shift cells up to pos, data into cell 0
        logic [POS_W-1:0] pos;    // slot to load, or index to decode
        logic [SYM_W-1:0] data;   // load symbol, or symbol moved to front
    } t_cell_ctl;

endpackage

>>> design/mtfd_cell.sv
// ---------------------------------------------------------------------------
// mtfd_cell
// One list slot: holds a symbol, takes its neighbor's symbol on a move.
// ---------------------------------------------------------------------------
module mtfd_cell
    import mtfd_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [POS_W-1:0] i_index,   // fixed place of this cell
    input  logic [SYM_W-1:0] i_prev,    // symbol of the cell in front
    output logic [SYM_W-1:0] o_sym,
    output logic [SYM_W-1:0] o_tap      // own symbol when addressed, else 0
);

    logic [SYM_W-1:0] r_sym;
    logic             hit;

    assign hit   = (i_ctl.pos == i_index);
    assign o_sym = r_sym;
    assign o_tap = hit ? r_sym : '0;

    // Load at the addressed slot, or shift down from the front
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && hit) begin
            r_sym <= i_ctl.data;
        end else if (i_ctl.move && (i_index <= i_ctl.pos)) begin
            r_sym <= i_prev;
        end
    end

endmodule

>>> design/mtfd_pick.sv
// ---------------------------------------------------------------------------
// mtfd_pick
// Two-stage registered OR tree that collects the addressed cell's symbol.
// ---------------------------------------------------------------------------
module mtfd_pick
    import mtfd_pkg::*;
(
    input  logic             i_clk,
    input  logic [SYM_W-1:0] i_taps [LIST_ENTRIES],
    output logic [SYM_W-1:0] o_pick
);

    logic [SYM_W-1:0] r_grp [NUM_GROUPS];
    logic [SYM_W-1:0] n_grp [NUM_GROUPS];
    logic [SYM_W-1:0] r_pick;
    logic [SYM_W-1:0] n_pick;

    // Fold each group of cells
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < LIST_ENTRIES) begin
                    n_grp[g] = n_grp[g] | i_taps[g * GROUP_SIZE + j];
                end
            end
        end
    end

    // Fold the groups
    always_comb begin
        n_pick = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_pick = n_pick | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp  <= n_grp;
        r_pick <= n_pick;
    end

    assign o_pick = r_pick;

endmodule

>>> design/inverse_move_to_front_decoder_unit.sv
// ---------------------------------------------------------------------------
// inverse_move_to_front_decoder_unit
// Inverse move-to-front decoder over a row of symbol cells.
// ---------------------------------------------------------------------------
// channel | direction | tdata                          | tuser
// s_axis  | in        | [7:0] position, [15:8] symbol_in | [0] kind
// m_axis  | out       | [7:0] symbol_out               | [0] index_error
//
// A load item is taken while idle and gives no result; the input stays ready.
// A decode item goes through accept, group fold, final fold and move; the
// two-stage read-out tree over the cell row sets these steps.
// An index error skips the read-out and goes from accept straight to the move.
// A finished result waits in the output register; the move stalls while it
// is full and not taken. Reset (i_rst_n low, synchronous) empties the list.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module inverse_move_to_front_decoder_unit
    import mtfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] position, [15:8] symbol_in
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] symbol_out
    output logic        m_axis_tuser    // [0] index_error
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_GATHER = 2'd1;
    localparam logic [1:0] S_PICK   = 2'd2;
    localparam logic [1:0] S_MOVE   = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [POS_W-1:0] r_pos;
    logic             r_err;
    logic             r_out_valid;
    logic [SYM_W-1:0] r_out_sym;
    logic             r_out_err;

    logic [POS_W-1:0] in_pos;
    logic [SYM_W-1:0] in_sym;
    logic             accept;
    logic             load_ok;
    logic             slot_free;
    logic             finish;
    logic [SYM_W-1:0] pick;
    t_cell_ctl        ctl;

    logic [SYM_W-1:0] cell_sym [LIST_ENTRIES];
    logic [SYM_W-1:0] cell_tap [LIST_ENTRIES];

    assign in_pos    = s_axis_tdata[POS_W-1:0];
    assign in_sym    = s_axis_tdata[POS_W +: SYM_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign load_ok   = ({1'b0, in_pos} < CNT_W'(LIST_ENTRIES));
    assign slot_free = !r_out_valid || m_axis_tready;
    assign finish    = (r_state == S_MOVE) && slot_free;

    // Drive the cell row
    always_comb begin
        ctl.load = accept && (s_axis_tuser == KIND_LOAD) && load_ok;
        ctl.move = finish && !r_err;
        ctl.pos  = (r_state == S_IDLE) ? in_pos : r_pos;
        ctl.data = (r_state == S_IDLE) ? in_sym : pick;
    end

    for (genvar k = 0; k < LIST_ENTRIES; k++) begin : g_cell
        if (k == 0) begin : g_front
            mtfd_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_index (POS_W'(k)),
                .i_prev  (ctl.data),
                .o_sym   (cell_sym[k]),
                .o_tap   (cell_tap[k])
            );
        end else begin : g_rest
            mtfd_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_index (POS_W'(k)),
                .i_prev  (cell_sym[k-1]),
                .o_sym   (cell_sym[k]),
                .o_tap   (cell_tap[k])
            );
        end
    end

    mtfd_pick u_pick (
        .i_clk  (i_clk),
        .i_taps (cell_tap),
        .o_pick (pick)
    );

    // Sequence one decode item
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (s_axis_tuser == KIND_DECODE)) begin
                    n_state = ({1'b0, in_pos} >= r_count) ? S_MOVE : S_GATHER;
                end
            end
            S_GATHER: n_state = S_PICK;
            S_PICK:   n_state = S_MOVE;
            S_MOVE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.load) begin
                r_count <= {1'b0, in_pos} + CNT_W'(1);
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the item and the result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos <= in_pos;
            r_err <= ({1'b0, in_pos} >= r_count);
        end
        if (finish) begin
            r_out_sym <= r_err ? '0 : pick;
            r_out_err <= r_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sym;
    assign m_axis_tuser  = r_out_err;

    `ASSERT_CLK(a_err_zero, !(r_out_valid && r_out_err) || (r_out_sym == '0),
        "error result carries a nonzero symbol")
    `ASSERT_CLK(a_count_max, r_count <= CNT_W'(LIST_ENTRIES),
        "entry count beyond list size")
    `ASSERT_CLK(a_err_match, (r_state != S_MOVE) || (r_err == ({1'b0, r_pos} >= r_count)),
        "error flag disagrees with entry count")
    `ASSERT_NEXT(a_move_out, finish, r_out_valid && (r_state == S_IDLE),
        "finished decode gave no result")

endmodule
